[rtl/lrupr_pkg.sv]
package lrupr_pkg;

  // Reset value of the frame count register
  localparam logic [3:0] FRAME_COUNT_RST = 4'd8;

  // Per-cycle command broadcast to every cell of the recency stack
  typedef struct packed {
    logic update;   // a lookup is being applied this cycle
    logic miss;     // the lookup missed: the whole stack pushes down
    logic trim;     // frame count written: drop frames beyond the new count
    logic compact;  // close holes left by a trim
  } cell_cmd_t;

endpackage

[rtl/lrupr_cell.sv]
// One slot of the recency stack. Slot 0 is the most recent entry.
// On an update the slot takes its upper neighbor when a match sits at or
// below it (or on any miss); during compaction it takes its lower neighbor
// when a hole sits at or above it.
module lrupr_cell #(
  parameter int FID_W     = 3,
  parameter int NW        = 4,
  parameter int PAGE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lrupr_pkg::cell_cmd_t  cmd,
  input  logic [PAGE_BITS-1:0]  req_page,
  input  logic [NW-1:0]         n_trim,
  input  logic                  prev_valid,
  input  logic [FID_W-1:0]      prev_fid,
  input  logic [PAGE_BITS-1:0]  prev_page,
  input  logic                  next_valid,
  input  logic [FID_W-1:0]      next_fid,
  input  logic [PAGE_BITS-1:0]  next_page,
  input  logic                  hit_below,
  input  logic                  hole_above,
  output logic                  valid,
  output logic [FID_W-1:0]      fid,
  output logic [PAGE_BITS-1:0]  page,
  output logic                  match,
  output logic                  hit_chain,
  output logic                  hole_chain
);

  // Lookup compare and neighbor chains
  assign match      = valid && (page == req_page);
  assign hit_chain  = match | hit_below;
  assign hole_chain = hole_above | !valid;

  // Slot contents
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.trim) begin
      if (NW'(fid) >= n_trim) valid <= 1'b0;
    end else if (cmd.compact && hole_chain) begin
      valid <= next_valid;
      fid   <= next_fid;
      page  <= next_page;
    end else if (cmd.update && (cmd.miss || hit_chain)) begin
      valid <= prev_valid;
      fid   <= prev_fid;
      page  <= prev_page;
    end
  end

endmodule

[rtl/lru_page_replacement.sv]
// LRU page replacement. One page reference is taken per item (start high while
// busy is low); the lookup runs in the following cycle while busy is high, and
// the result is shown with done, a one-cycle strobe, in the cycle after that, so
// a new reference is taken once the lookup is over. Frames are held in a chain
// of cells ordered by recency: every cell compares its page in parallel, and a
// hit or a miss moves the chosen entry to the head while the cells in front of
// it each pass their contents one place down. The receiver cannot stall: done
// is a one-cycle strobe and nothing is buffered behind it. Writing cfg_wdata
// (frame count, 0 acts as 1, values above FRAMES act as FRAMES) drops frames
// beyond the new count and then compacts the chain while sweep counts down,
// during which busy stays high. fault_count holds the saturating fault total.
module lru_page_replacement #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [PAGE_BITS-1:0] page,
  input  logic                 cfg_wr,
  input  logic [3:0]           cfg_wdata,
  output logic                 done,
  output logic                 hit,
  output logic [2:0]           frame,
  output logic                 evicted_valid,
  output logic [PAGE_BITS-1:0] evicted_page,
  output logic [31:0]          fault_count
);

  localparam int FID_W = $clog2(FRAMES);
  localparam int NW    = $clog2(FRAMES + 1);
  localparam int CW    = (NW > 4) ? NW : 4;
  localparam int SW    = $clog2(FRAMES);

  // Clamp a frame count value to 1..FRAMES
  function automatic logic [NW-1:0] clamp_n(input logic [3:0] v);
    logic [CW-1:0] w;
    w = CW'(v);
    if (w == '0) clamp_n = NW'(1);
    else if (w > CW'(FRAMES)) clamp_n = NW'(FRAMES);
    else clamp_n = NW'(w);
  endfunction

  logic [3:0]           frame_count;
  logic [NW-1:0]        n_act;
  logic [NW-1:0]        n_wr;
  logic                 work;
  logic [PAGE_BITS-1:0] req_page;
  logic [SW-1:0]        sweep;
  logic [FRAMES-1:0]    fv;
  logic [31:0]          faults;

  lrupr_pkg::cell_cmd_t cmd;

  logic [FRAMES-1:0]    c_valid;
  logic [FRAMES-1:0]    c_match;
  logic [FID_W-1:0]     c_fid  [FRAMES];
  logic [PAGE_BITS-1:0] c_page [FRAMES];
  logic [FRAMES:0]      hit_ch;
  logic [FRAMES:0]      hole_ch;

  logic                 hit_any;
  logic                 full;
  logic                 miss;
  logic [FID_W-1:0]     hit_fid;
  logic [FID_W-1:0]     vic_fid;
  logic [PAGE_BITS-1:0] vic_page;
  logic [FID_W-1:0]     free_id;
  logic [FID_W-1:0]     new_fid;
  logic [FID_W+2:0]     fid_wide;

  assign n_act = clamp_n(frame_count);
  assign n_wr  = clamp_n(cfg_wdata);
  assign busy  = work | (sweep != '0);

  // Command to the cells
  assign cmd.update  = work;
  assign cmd.miss    = miss;
  assign cmd.trim    = cfg_wr;
  assign cmd.compact = (sweep != '0);

  assign hit_ch[FRAMES] = 1'b0;
  assign hole_ch[0]     = 1'b0;

  // Recency chain
  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    logic                 p_valid;
    logic [FID_W-1:0]     p_fid;
    logic [PAGE_BITS-1:0] p_page;
    logic                 n_valid;
    logic [FID_W-1:0]     n_fid;
    logic [PAGE_BITS-1:0] n_page;

    if (g == 0) begin : g_head
      assign p_valid = 1'b1;
      assign p_fid   = new_fid;
      assign p_page  = req_page;
    end else begin : g_body
      // the evicted tail of the active stack falls off past the frame count
      assign p_valid = c_valid[g-1] && (NW'(g) < n_act);
      assign p_fid   = c_fid[g-1];
      assign p_page  = c_page[g-1];
    end

    if (g == FRAMES - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_fid   = '0;
      assign n_page  = '0;
    end else begin : g_inner
      assign n_valid = c_valid[g+1];
      assign n_fid   = c_fid[g+1];
      assign n_page  = c_page[g+1];
    end

    lrupr_cell #(
      .FID_W     (FID_W),
      .NW        (NW),
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .req_page   (req_page),
      .n_trim     (n_wr),
      .prev_valid (p_valid),
      .prev_fid   (p_fid),
      .prev_page  (p_page),
      .next_valid (n_valid),
      .next_fid   (n_fid),
      .next_page  (n_page),
      .hit_below  (hit_ch[g+1]),
      .hole_above (hole_ch[g]),
      .valid      (c_valid[g]),
      .fid        (c_fid[g]),
      .page       (c_page[g]),
      .match      (c_match[g]),
      .hit_chain  (hit_ch[g]),
      .hole_chain (hole_ch[g+1])
    );
  end

  // Hit frame, victim at the tail of the active stack, lowest free frame
  always_comb begin
    hit_fid  = '0;
    vic_fid  = '0;
    vic_page = '0;
    full     = 1'b0;
    free_id  = '0;
    for (int j = 0; j < FRAMES; j++) begin
      if (c_match[j]) hit_fid = hit_fid | c_fid[j];
      if (NW'(j + 1) == n_act) begin
        full     = c_valid[j];
        vic_fid  = c_fid[j];
        vic_page = c_page[j];
      end
    end
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (!fv[i] && (NW'(i) < n_act)) free_id = FID_W'(i);
    end
  end

  assign hit_any  = |c_match;
  assign miss     = work && !hit_any;
  assign new_fid  = hit_any ? hit_fid : (full ? vic_fid : free_id);
  assign fid_wide = {3'b000, new_fid};

  // Frame count register and compaction sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= lrupr_pkg::FRAME_COUNT_RST;
      sweep       <= '0;
    end else if (cfg_wr) begin
      frame_count <= cfg_wdata;
      sweep       <= SW'(FRAMES - 1);
    end else if (sweep != '0) begin
      sweep <= sweep - SW'(1);
    end
  end

  // Per-frame occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else if (cfg_wr) begin
      for (int i = 0; i < FRAMES; i++) begin
        if (NW'(i) >= n_wr) fv[i] <= 1'b0;
      end
    end else if (miss && !full) begin
      fv[free_id] <= 1'b1;
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (rst) begin
      work <= 1'b0;
    end else begin
      work <= start && !busy;
    end
    if (start && !busy) req_page <= page;
  end

  // Fault counter, saturating
  always_ff @(posedge clk) begin
    if (rst) begin
      faults <= '0;
    end else if (miss && (faults != '1)) begin
      faults <= faults + 32'd1;
    end
  end

  assign fault_count = faults;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= work;
    end
    if (work) begin
      hit           <= hit_any;
      frame         <= fid_wide[2:0];
      evicted_valid <= !hit_any && full;
      evicted_page  <= (!hit_any && full) ? vic_page : '0;
    end
  end

`ifndef SYNTHESIS
  a_one_match: assert property (@(posedge clk) disable iff (rst)
    work |-> $onehot0(c_match))
    else $error("more than one cell matched the page");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    done |-> !(hit && evicted_valid))
    else $error("hit reported together with an eviction");

  a_packed: assert property (@(posedge clk) disable iff (rst)
    (sweep == '0) |-> ((c_valid & (c_valid + FRAMES'(1))) == '0))
    else $error("recency stack has a hole after compaction");

  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    $countones(c_valid) == $countones(fv))
    else $error("stack entries and frame occupancy disagree");
`endif

endmodule
